// ----- hdl/gmd_pkg.sv -----
// Shared types, constants and helpers for the gzip member deframer.
`default_nettype none
package gmd_pkg;

    localparam int HEADER_BYTES  = 10;
    localparam int TRAILER_BYTES = 8;
    localparam int FILL_W        = $clog2(TRAILER_BYTES + 1);
    localparam int WIN_IDX_W     = $clog2(TRAILER_BYTES);

    localparam logic [7:0] MAGIC_FIRST  = 8'h1f;
    localparam logic [7:0] MAGIC_SECOND = 8'h8b;
    localparam logic [3:0] FLAG_POS     = 4'd3;
    localparam logic [3:0] HDR_LAST     = 4'(HEADER_BYTES - 1);

    localparam logic [7:0] FL_EXTRA   = 8'h04;
    localparam logic [7:0] FL_NAME    = 8'h08;
    localparam logic [7:0] FL_COMMENT = 8'h10;
    localparam logic [7:0] FL_HCRC    = 8'h02;

    typedef enum logic [2:0] {
        PH_FIXED   = 3'd0,
        PH_XLEN    = 3'd1,
        PH_XSKIP   = 3'd2,
        PH_NAME    = 3'd3,
        PH_COMMENT = 3'd4,
        PH_HCRC    = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_DISCARD = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MAGIC = 2'd1,
        ST_TRUNC     = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // One classified byte handed from front to back.
    typedef struct packed {
        logic [7:0] data;
        logic       pay;
        logic       fin;
        status_t    cls;
    } beat_t;

    function automatic phase_t next_section(input phase_t from, input logic [7:0] flags);
        phase_t res;
        res = PH_PAYLOAD;
        if (from <= PH_HCRC && (flags & FL_HCRC) != 8'd0) res = PH_HCRC;
        if (from <= PH_COMMENT && (flags & FL_COMMENT) != 8'd0) res = PH_COMMENT;
        if (from <= PH_NAME && (flags & FL_NAME) != 8'd0) res = PH_NAME;
        if (from <= PH_XLEN && (flags & FL_EXTRA) != 8'd0) res = PH_XLEN;
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/gzip_member_deframer.sv -----
// Top level of the gzip member deframer.
// Accepts one byte of a gzip member per cycle on the s_ channel, s_last on its
// final byte. A parser checks the magic, keeps the flag byte and skips header,
// extra, name, comment and header CRC; payload bytes and the final byte go
// through a two-entry queue to a trailer stage that holds the last eight bytes
// back. Sustained rate is one byte per cycle; a result beat is built from the
// queued byte and held in an output register until m_ready. While m_ready
// stays low the queue fills and s_ready drops.
// The final beat carries m_done_res, the status and the trailer CRC and size.
`default_nettype none
module gzip_member_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_done_res,
    output logic [1:0]       m_status,
    output logic [31:0]      m_trailer_crc,
    output logic [31:0]      m_trailer_size
);
    import gmd_pkg::*;

    beat_t fr_beat, q_data;
    logic  fr_push, q_full, q_valid, q_pop, accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    gmd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .last    (s_last),
        .beat    (fr_beat),
        .push    (fr_push)
    );

    gmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (fr_push),
        .wr_data   (fr_beat),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (q_data),
        .not_empty (q_valid)
    );

    gmd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_data         (q_data),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_done_res     (m_done_res),
        .m_status       (m_status),
        .m_trailer_crc  (m_trailer_crc),
        .m_trailer_size (m_trailer_size)
    );

endmodule
`default_nettype wire

// ----- hdl/gmd_front.sv -----
// Header parser: tracks the member's sections and classifies each byte.
`default_nettype none
module gmd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          last,
    output gmd_pkg::beat_t     beat,
    output logic               push
);
    import gmd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hcount_reg, hcount_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] xrem_reg, xrem_next;
    logic        err_reg, err_next;
    logic        bad_magic;

    assign bad_magic = (phase_reg == PH_FIXED) &&
                       ((hcount_reg == 4'd0 && in_byte != MAGIC_FIRST) ||
                        (hcount_reg == 4'd1 && in_byte != MAGIC_SECOND));

    always_comb begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        flags_next  = flags_reg;
        xrem_next   = xrem_reg;
        err_next    = err_reg;
        unique case (phase_reg)
            PH_FIXED: begin
                if (bad_magic) begin
                    err_next   = 1'b1;
                    phase_next = PH_DISCARD;
                end else begin
                    if (hcount_reg == FLAG_POS) flags_next = in_byte;
                    if (hcount_reg == HDR_LAST) begin
                        hcount_next = 4'd0;
                        phase_next  = next_section(PH_XLEN, flags_next);
                    end else begin
                        hcount_next = hcount_reg + 4'd1;
                    end
                end
            end
            PH_XLEN: begin
                if (hcount_reg == 4'd0) begin
                    xrem_next   = {8'd0, in_byte};
                    hcount_next = 4'd1;
                end else begin
                    xrem_next   = {in_byte, xrem_reg[7:0]};
                    hcount_next = 4'd0;
                    phase_next  = (xrem_next != 16'd0) ? PH_XSKIP
                                                       : next_section(PH_NAME, flags_reg);
                end
            end
            PH_XSKIP: begin
                if (xrem_reg <= 16'd1) begin
                    xrem_next  = 16'd0;
                    phase_next = next_section(PH_NAME, flags_reg);
                end else begin
                    xrem_next = xrem_reg - 16'd1;
                end
            end
            PH_NAME: begin
                if (in_byte == 8'd0) phase_next = next_section(PH_COMMENT, flags_reg);
            end
            PH_COMMENT: begin
                if (in_byte == 8'd0) phase_next = next_section(PH_HCRC, flags_reg);
            end
            PH_HCRC: begin
                if (hcount_reg == 4'd0) begin
                    hcount_next = 4'd1;
                end else begin
                    hcount_next = 4'd0;
                    phase_next  = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: ;
            PH_DISCARD: ;
            default: phase_next = PH_FIXED;
        endcase
    end

    always_comb begin
        beat.data = in_byte;
        beat.pay  = (phase_reg == PH_PAYLOAD);
        beat.fin  = last;
        if (err_next)                      beat.cls = ST_BAD_MAGIC;
        else if (phase_next != PH_PAYLOAD) beat.cls = ST_TRUNC;
        else                               beat.cls = ST_OK;
        push = accept && (beat.pay || last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && last)) begin
            phase_reg  <= PH_FIXED;
            hcount_reg <= 4'd0;
            flags_reg  <= 8'd0;
            xrem_reg   <= 16'd0;
            err_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            flags_reg  <= flags_next;
            xrem_reg   <= xrem_next;
            err_reg    <= err_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/gmd_fifo.sv -----
// Two-entry queue of classified beats between parser and trailer stage.
`default_nettype none
module gmd_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_en,
    input  gmd_pkg::beat_t     wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output gmd_pkg::beat_t     rd_data,
    output logic               not_empty
);
    import gmd_pkg::*;

    beat_t      mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rd_data   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (wr_en) wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule
`default_nettype wire

// ----- hdl/gmd_back.sv -----
// Trailer window: delays payload by eight bytes and builds result beats.
`default_nettype none
module gmd_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  gmd_pkg::beat_t     q_data,
    input  wire logic          q_valid,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_byte_valid,
    output logic               m_done_res,
    output logic [1:0]         m_status,
    output logic [31:0]        m_trailer_crc,
    output logic [31:0]        m_trailer_size
);
    import gmd_pkg::*;

    logic [7:0]        win_reg [TRAILER_BYTES];
    logic [7:0]        win_next [TRAILER_BYTES];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              seen_reg, seen_next;
    logic              full_win, emit, result;
    status_t           st;

    logic              m_valid_reg, m_valid_next;
    logic [7:0]        out_byte_reg;
    logic              byte_valid_reg, done_reg;
    status_t           status_reg;
    logic [31:0]       crc_reg, size_reg;

    assign q_pop    = q_valid && (!m_valid_reg || m_ready);
    assign full_win = (fill_reg >= FILL_W'(TRAILER_BYTES));
    assign emit     = q_data.pay && full_win;
    assign result   = emit || q_data.fin;

    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (q_data.pay) begin
            if (full_win) begin
                for (int i = 0; i < TRAILER_BYTES - 1; i++) win_next[i] = win_reg[i + 1];
                win_next[TRAILER_BYTES - 1] = q_data.data;
            end else begin
                win_next[fill_reg[WIN_IDX_W-1:0]] = q_data.data;
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        seen_next = seen_reg || emit;
        if (q_data.cls != ST_OK)                   st = q_data.cls;
        else if (fill_next < FILL_W'(TRAILER_BYTES)) st = ST_TRUNC;
        else if (seen_next)                        st = ST_OK;
        else                                       st = ST_EMPTY;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (q_pop && result)          m_valid_next = 1'b1;
        else if (m_valid_reg && m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            win_reg <= win_next;
        end
        if (q_pop && result) begin
            out_byte_reg   <= emit ? win_reg[0] : 8'd0;
            byte_valid_reg <= emit;
            done_reg       <= q_data.fin;
            status_reg     <= q_data.fin ? st : ST_OK;
            if (q_data.fin && (st == ST_OK || st == ST_EMPTY)) begin
                crc_reg  <= {win_next[3], win_next[2], win_next[1], win_next[0]};
                size_reg <= {win_next[7], win_next[6], win_next[5], win_next[4]};
            end else begin
                crc_reg  <= 32'd0;
                size_reg <= 32'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                fill_reg <= q_data.fin ? '0 : fill_next;
                seen_reg <= q_data.fin ? 1'b0 : seen_next;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_byte_valid   = byte_valid_reg;
    assign m_done_res     = done_reg;
    assign m_status       = status_reg;
    assign m_trailer_crc  = crc_reg;
    assign m_trailer_size = size_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(TRAILER_BYTES))
        else $error("trailer window overfilled");

    a_fill_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_data.fin |=> fill_reg == '0 && !seen_reg)
        else $error("window not cleared after member end");

    a_seen_full: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> fill_reg == FILL_W'(TRAILER_BYTES))
        else $error("payload released before window filled");

    a_err_words: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (status_reg == ST_BAD_MAGIC || status_reg == ST_TRUNC)
        |-> crc_reg == 32'd0 && size_reg == 32'd0)
        else $error("trailer words on failed member");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for gzip_member_deframer: directed members, then random byte streams.
`default_nettype none
module tb;
    import gmd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 320;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0]  ob;
        logic        bv;
        logic        done;
        status_t     st;
        logic [31:0] crc;
        logic [31:0] size;
    } deframed_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         pin;
        deframed_t  pinned;
    } tx_item_t;

    typedef struct {
        logic [7:0]  m0;
        logic [7:0]  m1;
        logic [7:0]  meth;
        logic [7:0]  flg;
        logic [15:0] xlen;
        int          nlen;
        int          clen;
        int          plen;
        int          cut;
        logic [31:0] crc;
        logic [31:0] size;
        logic [7:0]  pad;
        bit          pin;
        status_t     pin_st;
    } member_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_done_res;
    logic [1:0]  m_status;
    logic [31:0] m_trailer_crc;
    logic [31:0] m_trailer_size;

    gzip_member_deframer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_done_res     (m_done_res),
        .m_status       (m_status),
        .m_trailer_crc  (m_trailer_crc),
        .m_trailer_size (m_trailer_size)
    );

    tx_item_t  tx_q[$];
    deframed_t deframed_q[$];
    tx_item_t  tx_cur;
    int        errors = 0;
    int        cycles = 0;
    int        tx_idle = 17;
    int        rx_idle = 50;
    bit        hold_go = 1'b0;
    bit        hold_seen = 1'b0;
    int        hold_cnt = 0;

    // predictor state
    phase_t     dp_phase;
    logic [3:0] dp_hcnt;
    logic [7:0] dp_flags;
    logic [15:0] dp_xleft;
    logic [7:0] dp_win [TRAILER_BYTES];
    int         dp_fill;
    bit         dp_payload;
    bit         dp_badmagic;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic phase_t section_after(input phase_t from, input logic [7:0] f);
        if (from <= PH_XLEN && (f & FL_EXTRA) != 8'h00) return PH_XLEN;
        if (from <= PH_NAME && (f & FL_NAME) != 8'h00) return PH_NAME;
        if (from <= PH_COMMENT && (f & FL_COMMENT) != 8'h00) return PH_COMMENT;
        if (from <= PH_HCRC && (f & FL_HCRC) != 8'h00) return PH_HCRC;
        return PH_PAYLOAD;
    endfunction

    task automatic clear_deframer();
        dp_phase    = PH_FIXED;
        dp_hcnt     = 4'd0;
        dp_flags    = 8'h00;
        dp_xleft    = 16'd0;
        dp_fill     = 0;
        dp_payload  = 1'b0;
        dp_badmagic = 1'b0;
    endtask

    task automatic deframe_step(input logic [7:0] b, input logic fin,
                                output bit got, output deframed_t r);
        int j;
        got = 1'b0;
        r = '0;
        case (dp_phase)
            PH_FIXED: begin
                if ((dp_hcnt == 4'd0 && b != MAGIC_FIRST) ||
                    (dp_hcnt == 4'd1 && b != MAGIC_SECOND)) begin
                    dp_badmagic = 1'b1;
                    dp_phase = PH_DISCARD;
                end else begin
                    if (dp_hcnt == FLAG_POS) dp_flags = b;
                    dp_hcnt = dp_hcnt + 4'd1;
                    if (dp_hcnt >= HEADER_BYTES) begin
                        dp_hcnt = 4'd0;
                        dp_phase = section_after(PH_XLEN, dp_flags);
                    end
                end
            end
            PH_XLEN: begin
                if (dp_hcnt == 4'd0) begin
                    dp_xleft = {8'h00, b};
                    dp_hcnt = 4'd1;
                end else begin
                    dp_xleft = {b, dp_xleft[7:0]};
                    dp_hcnt = 4'd0;
                    dp_phase = (dp_xleft != 16'd0) ? PH_XSKIP
                                                   : section_after(PH_NAME, dp_flags);
                end
            end
            PH_XSKIP: begin
                if (dp_xleft <= 16'd1) begin
                    dp_xleft = 16'd0;
                    dp_phase = section_after(PH_NAME, dp_flags);
                end else begin
                    dp_xleft = dp_xleft - 16'd1;
                end
            end
            PH_NAME: begin
                if (b == 8'h00) dp_phase = section_after(PH_COMMENT, dp_flags);
            end
            PH_COMMENT: begin
                if (b == 8'h00) dp_phase = section_after(PH_HCRC, dp_flags);
            end
            PH_HCRC: begin
                if (dp_hcnt == 4'd0) begin
                    dp_hcnt = 4'd1;
                end else begin
                    dp_hcnt = 4'd0;
                    dp_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (dp_fill >= TRAILER_BYTES) begin
                    r.ob = dp_win[0];
                    r.bv = 1'b1;
                    dp_payload = 1'b1;
                    for (j = 0; j < TRAILER_BYTES - 1; j++) dp_win[j] = dp_win[j + 1];
                    dp_win[TRAILER_BYTES - 1] = b;
                end else begin
                    dp_win[dp_fill] = b;
                    dp_fill++;
                end
            end
            default: ;
        endcase
        if (r.bv || fin) begin
            got = 1'b1;
            r.done = fin;
            if (fin) begin
                if (dp_badmagic) begin
                    r.st = ST_BAD_MAGIC;
                end else if (dp_phase != PH_PAYLOAD || dp_fill < TRAILER_BYTES) begin
                    r.st = ST_TRUNC;
                end else begin
                    r.st   = dp_payload ? ST_OK : ST_EMPTY;
                    r.crc  = {dp_win[3], dp_win[2], dp_win[1], dp_win[0]};
                    r.size = {dp_win[7], dp_win[6], dp_win[5], dp_win[4]};
                end
                clear_deframer();
            end
        end
    endtask

    // Expands one member description into byte beats; cut > 0 ends it early.
    task automatic queue_member(input member_t m, input bit rnd);
        logic [7:0] mb[$];
        tx_item_t   t;
        int         n;
        int         i;
        mb.insert(mb.size(), m.m0);
        mb.insert(mb.size(), m.m1);
        mb.insert(mb.size(), m.meth);
        mb.insert(mb.size(), m.flg);
        repeat (6) mb.insert(mb.size(), rnd ? 8'($urandom_range(255)) : m.pad);
        if ((m.flg & FL_EXTRA) != 8'h00) begin
            mb.insert(mb.size(), m.xlen[7:0]);
            mb.insert(mb.size(), m.xlen[15:8]);
            repeat (m.xlen) mb.insert(mb.size(), rnd ? 8'($urandom_range(255)) : m.pad);
        end
        if ((m.flg & FL_NAME) != 8'h00) begin
            repeat (m.nlen)
                mb.insert(mb.size(), rnd ? 8'($urandom_range(255, 1))
                                         : (m.pad == 8'h00 ? 8'h01 : m.pad));
            mb.insert(mb.size(), 8'h00);
        end
        if ((m.flg & FL_COMMENT) != 8'h00) begin
            repeat (m.clen)
                mb.insert(mb.size(), rnd ? 8'($urandom_range(255, 1))
                                         : (m.pad == 8'h00 ? 8'h01 : m.pad));
            mb.insert(mb.size(), 8'h00);
        end
        if ((m.flg & FL_HCRC) != 8'h00)
            repeat (2) mb.insert(mb.size(), rnd ? 8'($urandom_range(255)) : m.pad);
        repeat (m.plen) mb.insert(mb.size(), rnd ? 8'($urandom_range(255)) : m.pad);
        for (i = 0; i < 4; i++) mb.insert(mb.size(), m.crc[8*i +: 8]);
        for (i = 0; i < 4; i++) mb.insert(mb.size(), m.size[8*i +: 8]);
        n = (m.cut > 0 && m.cut < mb.size()) ? m.cut : mb.size();
        for (i = 0; i < n; i++) begin
            t.b           = mb[i];
            t.last        = (i == n - 1);
            t.pin         = m.pin && (i == n - 1);
            t.pinned      = '0;
            t.pinned.done = 1'b1;
            t.pinned.st   = m.pin_st;
            if (m.pin_st == ST_EMPTY) begin
                t.pinned.crc  = m.crc;
                t.pinned.size = m.size;
            end
            tx_q.insert(tx_q.size(), t);
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (tx_q.size() != 0 || s_valid || deframed_q.size() != 0);
    endtask

    function automatic void check_field(input string name, input logic [31:0] e,
                                        input logic [31:0] a);
        if (e !== a) begin
            $display("%0t %s: expected %0h, got %0h", $time, name, e, a);
            errors++;
        end
    endfunction

    // sender
    always @(posedge aclk) begin
        bit        got;
        deframed_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                deframe_step(s_in_byte, s_last, got, r);
                if (got) deframed_q.insert(deframed_q.size(), tx_cur.pin ? tx_cur.pinned : r);
            end
            if (!s_valid || s_ready) begin
                if (tx_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
                    tx_cur = tx_q.pop_front();
                    s_valid   <= 1'b1;
                    s_in_byte <= tx_cur.b;
                    s_last    <= tx_cur.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        deframed_t e;
        if (aresetn && m_valid && m_ready) begin
            if (deframed_q.size() == 0) begin
                $display("%0t unexpected beat: expected none, got byte %0h done %0b",
                         $time, m_out_byte, m_done_res);
                errors++;
            end else begin
                e = deframed_q.pop_front();
                check_field("out_byte", e.ob, m_out_byte);
                check_field("byte_valid", e.bv, m_byte_valid);
                check_field("done_res", e.done, m_done_res);
                check_field("status", e.st, m_status);
                check_field("trailer_crc", e.crc, m_trailer_crc);
                check_field("trailer_size", e.size, m_trailer_size);
            end
        end
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_cnt  <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial begin : stim
        member_t  dir_rows [15];
        member_t  m;
        tx_item_t t;
        int       k;
        int       base;
        int       sent;
        int       pass_i;
        int       n;
        int       i;

        clear_deframer();
        // m0, m1, meth, flg, xlen, nlen, clen, plen, cut, crc, size, pad, pin, pin_st
        dir_rows = '{
            '{8'h00, MAGIC_SECOND, 8'h08, 8'h00, 16'd0, 0, 0, 0, 1,
              32'h0, 32'h0, 8'h00, 1'b1, ST_BAD_MAGIC},
            '{MAGIC_FIRST, 8'hff, 8'h08, 8'h00, 16'd0, 0, 0, 0, 0,
              32'h0, 32'h0, 8'hff, 1'b1, ST_BAD_MAGIC},
            '{MAGIC_FIRST, 8'h00, 8'h08, 8'h00, 16'd0, 0, 0, 0, 2,
              32'h0, 32'h0, 8'h00, 1'b1, ST_BAD_MAGIC},
            '{MAGIC_FIRST, MAGIC_SECOND, 8'h08, 8'h00, 16'd0, 0, 0, 0, 2,
              32'h0, 32'h0, 8'h00, 1'b1, ST_TRUNC},
            '{MAGIC_FIRST, MAGIC_SECOND, 8'h08, 8'h00, 16'd0, 0, 0, 0, 10,
              32'h0, 32'h0, 8'hff, 1'b1, ST_TRUNC},
            '{MAGIC_FIRST, MAGIC_SECOND, 8'h08, 8'h00, 16'd0, 0, 0, 0, 0,
              32'hffffffff, 32'h0, 8'h00, 1'b1, ST_EMPTY},
            '{MAGIC_FIRST, MAGIC_SECOND, 8'h08, 8'h00, 16'd0, 0, 0, 0, 17,
              32'h0, 32'h0, 8'h00, 1'b1, ST_TRUNC},
            '{MAGIC_FIRST, MAGIC_SECOND, 8'h00, 8'h00, 16'd0, 0, 0, 1, 0,
              32'h12345678, 32'h1, 8'hff, 1'b0, ST_OK},
            '{MAGIC_FIRST, MAGIC_SECOND, 8'hff, FL_EXTRA, 16'd0, 0, 0, 3, 0,
              32'hdeadbeef, 32'h3, 8'h5a, 1'b0, ST_OK},
            '{MAGIC_FIRST, MAGIC_SECOND, 8'h08, FL_EXTRA, 16'd1, 0, 0, 2, 0,
              32'h0, 32'h2, 8'ha5, 1'b0, ST_OK},
            '{MAGIC_FIRST, MAGIC_SECOND, 8'h08, FL_NAME | FL_COMMENT, 16'd0, 3, 0, 4, 0,
              32'h01020304, 32'h4, 8'h33, 1'b0, ST_OK},
            '{MAGIC_FIRST, MAGIC_SECOND, 8'h08, FL_HCRC, 16'd0, 0, 0, 2, 0,
              32'h80000001, 32'h2, 8'h00, 1'b0, ST_OK},
            '{MAGIC_FIRST, MAGIC_SECOND, 8'h08, 8'hff, 16'h0100, 2, 2, 5, 0,
              32'hcafef00d, 32'h5, 8'hff, 1'b0, ST_OK},
            '{MAGIC_FIRST, MAGIC_SECOND, 8'h08, FL_NAME, 16'd0, 5, 0, 0, 13,
              32'h0, 32'h0, 8'h41, 1'b1, ST_TRUNC},
            '{MAGIC_FIRST, MAGIC_SECOND, 8'h08, 8'h00, 16'd0, 0, 0, 40, 0,
              32'hffffffff, 32'hffffffff, 8'h00, 1'b0, ST_OK}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[r]) queue_member(dir_rows[r], 1'b0);
        wait_drained();

        for (pass_i = 0; pass_i < 3; pass_i++) begin
            tx_idle = (pass_i == 0) ? 17 : (pass_i == 1) ? 50 : 0;
            rx_idle = (pass_i == 0) ? 50 : (pass_i == 1) ? 17 : 0;
            if (pass_i == 0) hold_go = ~hold_go;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                base = tx_q.size();
                k = $urandom_range(99);
                if (k < 8) begin
                    // noise: random bytes ending on a last beat
                    n = $urandom_range(12, 1);
                    for (i = 0; i < n; i++) begin
                        t.b      = 8'($urandom_range(255));
                        t.last   = (i == n - 1);
                        t.pin    = 1'b0;
                        t.pinned = '0;
                        tx_q.insert(tx_q.size(), t);
                    end
                end else begin
                    m.m0     = MAGIC_FIRST;
                    m.m1     = MAGIC_SECOND;
                    m.meth   = 8'($urandom_range(255));
                    m.flg    = 8'($urandom_range(255));
                    m.xlen   = ($urandom_range(19) == 0) ? 16'($urandom_range(300))
                                                         : 16'($urandom_range(6));
                    m.nlen   = $urandom_range(6);
                    m.clen   = $urandom_range(6);
                    m.plen   = ($urandom_range(9) == 0) ? $urandom_range(80)
                                                        : $urandom_range(12);
                    m.cut    = 0;
                    m.crc    = $urandom;
                    m.size   = $urandom;
                    m.pad    = 8'h00;
                    m.pin    = 1'b0;
                    m.pin_st = ST_OK;
                    if (k < 16) begin
                        if ($urandom_range(1) == 1) m.m0 = 8'($urandom_range(255));
                        else m.m1 = 8'($urandom_range(255));
                        if ($urandom_range(1) == 1) m.cut = $urandom_range(20, 1);
                    end else if (k < 28) begin
                        m.cut = $urandom_range(40, 1);
                    end
                    queue_member(m, 1'b1);
                end
                sent += tx_q.size() - base;
                while (tx_q.size() > 64) @(negedge aclk);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0 && deframed_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- gzip_member_deframer.f -----
hdl/gmd_pkg.sv
hdl/gmd_front.sv
hdl/gmd_fifo.sv
hdl/gmd_back.sv
hdl/gzip_member_deframer.sv
tb/tb.sv
